// ===== src/fna_pkg.sv =====
// Shared types and constants for the Frobenius norm accumulator.
// No dependencies; every other file in src imports this package.
package fna_pkg;

    // Accumulator width (Q32.16 sum of squares)
    localparam int ACC_WIDTH  = 48;
    localparam int ELEM_W     = 16;
    // Largest square is 2^30, so one bit less than the full product
    localparam int SQ_W       = 2 * ELEM_W - 1;
    localparam int NORM_W     = 24;
    // One root bit per step
    localparam int ROOT_STEPS = (ACC_WIDTH + 1) / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    localparam logic [NORM_W-1:0]    NORM_MAX      = {NORM_W{1'b1}};
    localparam logic [ACC_WIDTH-1:0] ROOT_BIT_INIT =
        ACC_WIDTH'(1) << (2 * (ROOT_STEPS - 1));

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     is_last;
    } in_t;

    typedef struct packed {
        logic [NORM_W-1:0] norm_value;
        logic              overflowed;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic take;        // input beat accepted this cycle
        logic load_root;   // fold last square, seed root unit, clear sum
        logic root_step;   // run one root iteration
        logic emit;        // write result into output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;    // output register holds a beat not taken
    } dp_status_t;

endpackage

// ===== src/fna_datapath.sv =====
// Datapath: squarer, saturating accumulator, iterative root unit, output register.
// Depends on fna_pkg; driven by fna_ctrl through dp_cmd_t.
module fna_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  fna_pkg::in_t       s_data,
    input  fna_pkg::dp_cmd_t   cmd,
    output fna_pkg::dp_status_t status,
    output fna_pkg::out_t      m_data,
    output logic               m_valid,
    input  logic               m_ready
);
    import fna_pkg::*;

    logic [ELEM_W-1:0]    mag;
    logic [SQ_W-1:0]      sq_next;
    logic [SQ_W-1:0]      sq_reg;
    logic                 sq_vld_reg;
    logic [SQ_W-1:0]      sq_add;
    logic [ACC_WIDTH:0]   sum_ext;
    logic [ACC_WIDTH-1:0] sum_sat;
    logic                 sat_next;
    logic [ACC_WIDTH-1:0] acc_reg;
    logic                 sat_reg;
    logic [ACC_WIDTH-1:0] rem_reg;
    logic [ACC_WIDTH-1:0] root_reg;
    logic [ACC_WIDTH-1:0] bit_reg;
    logic                 ovf_reg;
    logic [ACC_WIDTH:0]   trial;
    logic                 fits;
    logic                 root_big;
    out_t                 out_next;
    out_t                 out_reg;
    logic                 m_valid_reg;

    // Magnitude and exact square of the incoming element
    always_comb begin
        mag     = s_data.element_value[ELEM_W-1] ?
                  (~s_data.element_value + ELEM_W'(1)) : s_data.element_value;
        sq_next = SQ_W'(mag * mag);
    end

    // Saturating add of the registered square
    always_comb begin
        sq_add   = sq_vld_reg ? sq_reg : '0;
        sum_ext  = {1'b0, acc_reg} + (ACC_WIDTH + 1)'(sq_add);
        sum_sat  = sum_ext[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum_ext[ACC_WIDTH-1:0];
        sat_next = sat_reg | sum_ext[ACC_WIDTH];
    end

    // One restoring root iteration
    always_comb begin
        trial = {1'b0, root_reg} + {1'b0, bit_reg};
        fits  = ({1'b0, rem_reg} >= trial);
    end

    // Clamp the final root to the output width
    always_comb begin
        root_big            = (root_reg > ACC_WIDTH'(NORM_MAX));
        out_next.norm_value = root_big ? NORM_MAX : root_reg[NORM_W-1:0];
        out_next.overflowed = ovf_reg | root_big;
    end

    // Square stage and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
        end else begin
            sq_vld_reg <= cmd.take;
            if (cmd.load_root) begin
                acc_reg <= '0;
                sat_reg <= 1'b0;
            end else begin
                acc_reg <= sum_sat;
                sat_reg <= sat_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sq_reg <= sq_next;
        end
    end

    // Root unit: seed from the final sum, then one bit per step
    always_ff @(posedge aclk) begin
        if (cmd.load_root) begin
            rem_reg  <= sum_sat;
            ovf_reg  <= sat_next;
            root_reg <= '0;
            bit_reg  <= ROOT_BIT_INIT;
        end else if (cmd.root_step) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial[ACC_WIDTH-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg <= out_next;
        end
    end

    assign m_data          = out_reg;
    assign m_valid         = m_valid_reg;
    assign status.out_busy = m_valid_reg & ~m_ready;

endmodule

// ===== src/fna_ctrl.sv =====
// Controller state machine: input handshake, root step count, result hand-off.
// Depends on fna_pkg; commands fna_datapath.
module fna_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    output logic                s_ready,
    input  fna_pkg::dp_status_t status,
    output fna_pkg::dp_cmd_t    cmd
);
    import fna_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LAST,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Decode commands from state
    always_comb begin
        s_ready       = (state_reg == ST_ACCUM);
        cmd.take      = s_ready & s_valid;
        cmd.load_root = (state_reg == ST_LAST);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.emit      = (state_reg == ST_DONE) & ~status.out_busy;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_valid && s_last) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                cnt_next   = CNT_W'(ROOT_STEPS - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    // Hold state and step count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/frobenius_norm_accumulator.sv =====
// Frobenius norm accumulator: sum of squares of Q8.8 elements, floor root out.
// Throughput: one element per cycle; a last element blocks input while the
// one-bit-per-cycle root unit runs and until the result enters the output register.
// Result: ST_LAST folds the last square, ST_ROOT iterates the root, ST_DONE emits it.
// Reset: aresetn synchronous, active low; clears sum, saturation flag and valid state.
// Depends on fna_pkg, fna_ctrl, fna_datapath.
module frobenius_norm_accumulator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fna_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fna_pkg::out_t m_data
);
    import fna_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fna_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.is_last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fna_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

`ifndef SYNTH
    // A last beat closes the input until its root is done
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.is_last) |=> !s_ready)
        else $error("input open after last beat");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid && !m_ready))
        else $error("result overwritten");

    // Results appear only while input is closed for the root
    a_emit_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_ready)
        else $error("emit while accepting input");
`endif

endmodule
